// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed: condition violated");

// Antecedent in one cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication violated");

`endif

// ===== sv/rcb_pkg.sv =====
// Shared types, constants and the digit glyph function for the radix converter.
`timescale 1ns / 1ps

package rcb_pkg;

    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_A    = 7'h41;
    localparam logic [4:0] BASE_MIN  = 5'd2;
    localparam logic [4:0] BASE_MAX  = 5'd16;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture value and base, clear digit count
        logic load_err;  // present the error word
        logic div_step;  // one quotient bit
        logic store;     // write remainder digit, start next division
        logic emit;      // present the digit read from storage
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic bad_base;
        logic div_done;
        logic quot_zero;
        logic cnt_last;
        logic idx_zero;
    } t_sts;

    function automatic logic [6:0] glyph(input logic [3:0] d);
        logic [6:0] res;
        if (d < 4'd10) begin
            res = CHAR_ZERO + {3'b000, d};
        end else begin
            res = CHAR_A + {3'b000, d} - 7'd10;
        end
        return res;
    endfunction

endpackage

// ===== sv/rcb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rcb_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rcb_ctrl.sv =====
// Sequencer for the radix converter: divide loop, digit store and readout.
`timescale 1ns / 1ps

module rcb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  rcb_pkg::t_sts i_sts,
    output rcb_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    import rcb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_STORE = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_sts.bad_base) begin
                        cmd.load_err = 1'b1;
                    end else begin
                        cmd.load = 1'b1;
                        n_state  = S_DIV;
                    end
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                cmd.store = 1'b1;
                // quotient zero, or storage full: only low digits are kept
                if (i_sts.quot_zero || i_sts.cnt_last) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                cmd.emit = 1'b1;
                if (i_sts.idx_zero) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== sv/rcb_dpath.sv =====
// Datapath: bit-serial divider by the radix, digit store and output word register.
`timescale 1ns / 1ps

module rcb_dpath #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [4:0]            i_base,
    input  rcb_pkg::t_cmd         i_cmd,
    output rcb_pkg::t_sts         o_sts,
    output logic                  o_strobe,
    output logic [6:0]            o_digit_char,
    output logic                  o_last,
    output logic                  o_bad_base
);

    import rcb_pkg::*;

    localparam int BIT_W  = $clog2(VALUE_BITS);
    localparam int ADDR_W = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

    logic [VALUE_BITS-1:0] r_val;
    logic [3:0]            r_rem;
    logic [4:0]            r_base;
    logic [BIT_W-1:0]      r_bit_cnt;
    logic [CNT_W-1:0]      r_cnt;
    logic [ADDR_W-1:0]     r_idx;
    logic                  r_strobe;
    logic [6:0]            r_char;
    logic                  r_last;
    logic                  r_bad;

    logic [4:0]            trial;
    logic                  q_bit;
    logic [3:0]            n_rem;
    logic [3:0]            rdata;
    logic                  bad_base;

    always_comb begin
        bad_base = !(i_base inside {[BASE_MIN:BASE_MAX]});
    end

    // restoring step: shift next dividend bit into the remainder
    always_comb begin
        trial = {r_rem, r_val[VALUE_BITS-1]};
        q_bit = (trial >= r_base);
        n_rem = q_bit ? 4'(trial - r_base) : trial[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val     <= i_value;
            r_base    <= i_base;
            r_rem     <= '0;
            r_bit_cnt <= BIT_W'(VALUE_BITS - 1);
            r_cnt     <= '0;
        end
        if (i_cmd.div_step) begin
            r_val     <= {r_val[VALUE_BITS-2:0], q_bit};
            r_rem     <= n_rem;
            r_bit_cnt <= r_bit_cnt - 1'b1;
        end
        if (i_cmd.store) begin
            r_rem     <= '0;
            r_bit_cnt <= BIT_W'(VALUE_BITS - 1);
            r_cnt     <= r_cnt + 1'b1;
            r_idx     <= r_cnt[ADDR_W-1:0];
        end
        if (i_cmd.emit && (r_idx != '0)) begin
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.emit) begin
            r_char <= glyph(rdata);
            r_last <= (r_idx == '0);
            r_bad  <= 1'b0;
        end
        if (i_cmd.load_err) begin
            r_char <= '0;
            r_last <= 1'b1;
            r_bad  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit | i_cmd.load_err;
        end
    end

    rcb_ram #(
        .WIDTH(4),
        .DEPTH(MAX_DIGITS)
    ) u_digits (
        .i_clk  (i_clk),
        .i_we   (i_cmd.store),
        .i_waddr(r_cnt[ADDR_W-1:0]),
        .i_wdata(r_rem),
        .i_raddr(r_idx),
        .o_rdata(rdata)
    );

    always_comb begin
        o_sts.bad_base  = bad_base;
        o_sts.div_done  = (r_bit_cnt == '0);
        o_sts.quot_zero = (r_val == '0);
        o_sts.cnt_last  = (r_cnt == CNT_W'(MAX_DIGITS - 1));
        o_sts.idx_zero  = (r_idx == '0);
    end

    assign o_strobe     = r_strobe;
    assign o_digit_char = r_char;
    assign o_last       = r_last;
    assign o_bad_base   = r_bad;

endmodule

// ===== sv/radix_converter_base2_to_16.sv =====
// Radix converter: each digit comes from the serial divider and is then stored in the digit RAM.
// Readout of each digit goes through the registered digit RAM read, then the output word register.
// A bad radix yields the error word in the cycle after start is taken.
// busy drops with the last word, so the next start is taken in that same cycle.
// Results appear as single-cycle strobed words; the receiver cannot stall.
// Synchronous active-low reset clears the sequencer and the strobe; RAM needs no clear.
`timescale 1ns / 1ps

module radix_converter_base2_to_16 #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic [4:0]            i_base,
    output logic                  o_strobe,
    output logic [6:0]            o_digit_char,
    output logic                  o_last,
    output logic                  o_bad_base
);

    import rcb_pkg::*;

    `include "assert_macros.svh"

    t_cmd cmd;
    t_sts sts;
    logic in_acc;
    logic err_out;

    rcb_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    rcb_dpath #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_DIGITS(MAX_DIGITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_base      (i_base),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_strobe    (o_strobe),
        .o_digit_char(o_digit_char),
        .o_last      (o_last),
        .o_bad_base  (o_bad_base)
    );

    assign in_acc  = start && !busy;
    assign err_out = o_strobe && o_bad_base && o_last && (o_digit_char == 7'd0);

    `ASSERT_NEXT(a_err_word, i_clk, i_rst_n, in_acc && sts.bad_base, err_out && !busy)
    `ASSERT_NEXT(a_good_busy, i_clk, i_rst_n, in_acc && !sts.bad_base, busy && !o_strobe)
    `ASSERT_IMPLIES(a_last_idle, i_clk, i_rst_n, o_strobe && o_last && !o_bad_base, !busy)
    `ASSERT_IMPLIES(a_mid_busy, i_clk, i_rst_n, o_strobe && !o_last, busy && !o_bad_base)

endmodule
